/* rtl/palette_remap_image_scaler_defines.svh */
// Assertion macros used by the checker file of the scaler.
`ifndef PALETTE_REMAP_IMAGE_SCALER_DEFINES_SVH
`define PALETTE_REMAP_IMAGE_SCALER_DEFINES_SVH

// Clocked assertion, off while reset is held.
`define PRS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is held.
`define PRS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/prs_pkg.sv */
`default_nettype none

package prs_pkg;

    // Input item modes
    localparam logic [1:0] MODE_PAL  = 2'd0;
    localparam logic [1:0] MODE_SRC  = 2'd1;
    localparam logic [1:0] MODE_EMIT = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;
    localparam logic [CFG_INDEX_W-1:0] REG_TOP_COLOR     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BOTTOM_COLOR  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TOP_BASE      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BOTTOM_BASE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_WIDTH  = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_HEIGHT = 3'd7;

    // Configuration reset values
    localparam logic [3:0] RST_TOP_COLOR     = 4'd0;
    localparam logic [3:0] RST_BOTTOM_COLOR  = 4'd0;
    localparam logic [7:0] RST_TOP_BASE      = 8'd16;
    localparam logic [7:0] RST_BOTTOM_BASE   = 8'd96;
    localparam logic [9:0] RST_SOURCE_WIDTH  = 10'd296;
    localparam logic [8:0] RST_SOURCE_HEIGHT = 9'd194;
    localparam logic [9:0] RST_OUTPUT_WIDTH  = 10'd512;
    localparam logic [8:0] RST_OUTPUT_HEIGHT = 9'd256;

    // Column accumulator (10.16, wraps at 26 bits) and divider sizes
    localparam int FRAC_W        = 26;
    localparam int FRAC_SHIFT    = 16;
    localparam int DIVISOR_W     = 11;
    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = 8;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] address;
        logic [31:0] value;
    } in_t;

    typedef struct packed {
        logic [7:0]  color_index;
        logic [31:0] rgba;
        logic        row_end;
        logic        frame_end;
        logic        size_error;
    } out_t;

    typedef struct packed {
        logic [3:0] top_color;
        logic [3:0] bottom_color;
        logic [7:0] top_range_base;
        logic [7:0] bottom_range_base;
        logic [9:0] source_width;
        logic [8:0] source_height;
        logic [9:0] output_width;
        logic [8:0] output_height;
    } cfg_t;

endpackage

`default_nettype wire

/* rtl/prs_fifo.sv */
`default_nettype none

module prs_fifo #(
    parameter int WIDTH = 50,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);

    // DEPTH of two or more
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    // Store the pushed transfer
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

/* rtl/prs_divider.sv */
`default_nettype none

module prs_divider (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [prs_pkg::FRAC_W-1:0]    dividend,
    input  logic [prs_pkg::DIVISOR_W-1:0] divisor,
    output logic                           done,
    output logic [prs_pkg::FRAC_W-1:0]    quotient
);

    localparam int NW     = prs_pkg::FRAC_W;
    localparam int DW     = prs_pkg::DIVISOR_W;
    localparam int STEP_W = $clog2(NW);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DW-1:0]     rem_reg;
    logic [DW-1:0]     divisor_reg;
    logic [NW-1:0]     work_reg;
    logic [DW:0]       trial;
    logic [DW:0]       diff;
    logic              fits;
    logic [DW-1:0]     rem_step;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign trial    = {rem_reg, work_reg[NW-1]};
    assign diff     = trial - {1'b0, divisor_reg};
    assign fits     = (trial >= {1'b0, divisor_reg});
    assign rem_step = fits ? diff[DW-1:0] : trial[DW-1:0];

    assign done     = done_reg;
    assign quotient = work_reg;

    // Sequence the quotient bits, one per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + STEP_W'(1);
            if (cnt_reg == STEP_W'(NW - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Hold remainder and dividend/quotient word
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg    <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_step;
            work_reg <= {work_reg[NW-2:0], fits};
        end
    end

endmodule

`default_nettype wire

/* rtl/prs_front.sv */
`default_nettype none

module prs_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  prs_pkg::in_t   item,
    output logic           cmd_push,
    input  logic           cmd_full,
    output prs_pkg::in_t   cmd
);

    logic         valid_reg;
    logic         valid_next;
    prs_pkg::in_t cmd_reg;
    logic         accept;
    logic         keep;
    logic         drain;

    // Accept whenever the holding stage is free or moving on
    assign full     = valid_reg && cmd_full;
    assign accept   = push && !full;
    assign keep     = (item.mode != prs_pkg::MODE_NONE);
    assign drain    = valid_reg && !cmd_full;
    assign cmd_push = valid_reg;
    assign cmd      = cmd_reg;

    // Drop unused modes here; the back end only sees real commands
    assign valid_next = (valid_reg && !drain) || (accept && keep);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load the classified command
    always_ff @(posedge clk)
    begin
        if (accept && keep)
        begin
            cmd_reg <= item;
        end
    end

endmodule

`default_nettype wire

/* rtl/prs_back.sv */
`default_nettype none

module prs_back #(
    parameter int SOURCE_DEPTH   = 65536,
    parameter int MAX_OUT_WIDTH  = 512,
    parameter int MAX_OUT_HEIGHT = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  prs_pkg::cfg_t  cfg,
    input  logic           cmd_empty,
    output logic           cmd_pop,
    input  prs_pkg::in_t   cmd,
    input  logic           res_full,
    output logic           res_push,
    output prs_pkg::out_t  res
);

    localparam int AW     = $clog2(SOURCE_DEPTH);
    localparam int CW     = $clog2(MAX_OUT_WIDTH);
    localparam int RW     = $clog2(MAX_OUT_HEIGHT);
    localparam int FW     = prs_pkg::FRAC_W;
    localparam int DW     = prs_pkg::DIVISOR_W;
    localparam int QW     = RW + 9;
    localparam int PIX_W  = (AW + 1 > 19) ? AW + 1 : 19;
    localparam logic [7:0] RANGE_SPAN = 8'd16;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DIV_STEP = 3'd1;
    localparam logic [2:0] ST_DIV_ROW  = 3'd2;
    localparam logic [2:0] ST_ROW_BASE = 3'd3;
    localparam logic [2:0] ST_FETCH    = 3'd4;
    localparam logic [2:0] ST_COLOR    = 3'd5;
    localparam logic [2:0] ST_PUSH     = 3'd6;

    function automatic logic range_hit(input logic [7:0] idx, input logic [7:0] base);
        logic [7:0] d;
        d = idx - base;
        return (idx >= base) && (d < RANGE_SPAN);
    endfunction

    // Upper color rows run the range backwards
    function automatic logic [7:0] range_index(input logic [7:0] idx,
                                               input logic [7:0] base,
                                               input logic [3:0] color);
        logic [7:0] d;
        d = idx - base;
        return color[3] ? {color, ~d[3:0]} : {color, d[3:0]};
    endfunction

    logic [2:0]      state_reg;
    logic [2:0]      state_next;
    logic [CW-1:0]   out_col_reg;
    logic [RW-1:0]   out_row_reg;
    logic [FW-1:0]   frac_reg;
    logic [FW-1:0]   step_reg;
    logic [AW-1:0]   row_base_reg;
    logic [QW-1:0]   quot_reg;
    logic [7:0]      src_q_reg;
    logic [7:0]      ci_reg;
    logic [31:0]     pal_q_reg;
    logic            rend_reg;
    logic            fend_reg;
    logic            err_reg;

    logic [7:0]      src_mem [SOURCE_DEPTH];
    logic [31:0]     pal_mem [prs_pkg::PALETTE_DEPTH];

    logic [9:0]      eff_sw;
    logic [8:0]      eff_sh;
    logic [DW-1:0]   ow_masked;
    logic [DW-1:0]   oh_raw;
    logic [DW-1:0]   eff_ow;
    logic [DW-1:0]   eff_oh;
    logic            is_emit;
    logic            col_zero;
    logic            div_start;
    logic [FW-1:0]   div_dividend;
    logic [DW-1:0]   div_divisor;
    logic            div_done;
    logic [FW-1:0]   div_q;
    logic [QW-1:0]   row_prod;
    logic [QW+9:0]   base_prod;
    logic [AW-1:0]   src_addr;
    logic [PIX_W-1:0] pixels;
    logic            err;
    logic            rend;
    logic            fend;
    logic [7:0]      ci;
    logic            pal_we;
    logic            src_we;

    // Effective sizes: a zero source size or output height acts as one; output width rounded down to four and clamped
    assign eff_sw    = (cfg.source_width == '0) ? 10'd1 : cfg.source_width;
    assign eff_sh    = (cfg.source_height == '0) ? 9'd1 : cfg.source_height;
    assign ow_masked = {1'b0, cfg.output_width[9:2], 2'b00};
    assign oh_raw    = {2'b00, cfg.output_height};

    always_comb
    begin
        eff_ow = ow_masked;
        if (ow_masked < DW'(4))
        begin
            eff_ow = DW'(4);
        end
        if (ow_masked > DW'(MAX_OUT_WIDTH))
        begin
            eff_ow = DW'(MAX_OUT_WIDTH);
        end
        eff_oh = (oh_raw == '0) ? DW'(1) : oh_raw;
        if (oh_raw > DW'(MAX_OUT_HEIGHT))
        begin
            eff_oh = DW'(MAX_OUT_HEIGHT);
        end
    end

    // Dispatch one command at a time; an emit waits for result room
    assign is_emit  = (cmd.mode == prs_pkg::MODE_EMIT);
    assign col_zero = (out_col_reg == '0);
    assign cmd_pop  = (state_reg == ST_IDLE) && !cmd_empty && (!is_emit || !res_full);
    assign pal_we   = cmd_pop && (cmd.mode == prs_pkg::MODE_PAL);
    assign src_we   = cmd_pop && (cmd.mode == prs_pkg::MODE_SRC);

    // Row start: column step first, then the source row
    assign row_prod  = QW'(out_row_reg) * QW'(eff_sh);
    assign base_prod = (QW + 10)'(eff_sw) * (QW + 10)'(quot_reg);

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = eff_ow;
        if (cmd_pop && is_emit && col_zero)
        begin
            div_start    = 1'b1;
            div_dividend = {eff_sw, 16'd0};
            div_divisor  = eff_ow;
        end
        else if ((state_reg == ST_DIV_STEP) && div_done)
        begin
            div_start    = 1'b1;
            div_dividend = FW'(row_prod);
            div_divisor  = eff_oh;
        end
    end

    prs_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // Pixel address, flags and recolor
    assign src_addr = row_base_reg + AW'(frac_reg[FW-1:prs_pkg::FRAC_SHIFT]);
    assign pixels   = PIX_W'(eff_sw) * PIX_W'(eff_sh);
    assign err      = (pixels[1:0] != 2'b00) || (pixels > PIX_W'(SOURCE_DEPTH));
    assign rend     = ((DW'(out_col_reg) + DW'(1)) >= eff_ow);
    assign fend     = rend && ((DW'(out_row_reg) + DW'(1)) >= eff_oh);

    always_comb
    begin
        if (range_hit(src_q_reg, cfg.bottom_range_base))
        begin
            ci = range_index(src_q_reg, cfg.bottom_range_base, cfg.bottom_color);
        end
        else if (range_hit(src_q_reg, cfg.top_range_base))
        begin
            ci = range_index(src_q_reg, cfg.top_range_base, cfg.top_color);
        end
        else
        begin
            ci = src_q_reg;
        end
    end

    assign res_push       = (state_reg == ST_PUSH);
    assign res.color_index = ci_reg;
    assign res.rgba        = pal_q_reg;
    assign res.row_end     = rend_reg;
    assign res.frame_end   = fend_reg;
    assign res.size_error  = err_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_pop && is_emit)
                begin
                    state_next = col_zero ? ST_DIV_STEP : ST_FETCH;
                end
            end
            ST_DIV_STEP:
            begin
                if (div_done)
                begin
                    state_next = ST_DIV_ROW;
                end
            end
            ST_DIV_ROW:
            begin
                if (div_done)
                begin
                    state_next = ST_ROW_BASE;
                end
            end
            ST_ROW_BASE: state_next = ST_FETCH;
            ST_FETCH:    state_next = ST_COLOR;
            ST_COLOR:    state_next = ST_PUSH;
            ST_PUSH:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Advance state, position and column accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            frac_reg     <= '0;
            step_reg     <= '0;
            row_base_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_DIV_STEP) && div_done)
            begin
                step_reg <= div_q;
                frac_reg <= div_q >> 1;
            end
            if (state_reg == ST_ROW_BASE)
            begin
                row_base_reg <= AW'(base_prod);
            end
            if (state_reg == ST_FETCH)
            begin
                frac_reg <= frac_reg + step_reg;
                if (rend)
                begin
                    out_col_reg <= '0;
                    out_row_reg <= fend ? '0 : out_row_reg + RW'(1);
                end
                else
                begin
                    out_col_reg <= out_col_reg + CW'(1);
                end
            end
        end
    end

    // Hold row quotient, pixel flags and recolored index
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DIV_ROW) && div_done)
        begin
            quot_reg <= QW'(div_q);
        end
        if (state_reg == ST_FETCH)
        begin
            rend_reg <= rend;
            fend_reg <= fend;
            err_reg  <= err;
        end
        if (state_reg == ST_COLOR)
        begin
            ci_reg <= ci;
        end
    end

    // Source image store
    always_ff @(posedge clk)
    begin
        if (src_we)
        begin
            src_mem[AW'(cmd.address)] <= cmd.value[7:0];
        end
        if (state_reg == ST_FETCH)
        begin
            src_q_reg <= src_mem[src_addr];
        end
    end

    // Palette store
    always_ff @(posedge clk)
    begin
        if (pal_we)
        begin
            pal_mem[cmd.address[prs_pkg::PAL_AW-1:0]] <= cmd.value;
        end
        if (state_reg == ST_COLOR)
        begin
            pal_q_reg <= pal_mem[ci];
        end
    end

endmodule

`default_nettype wire

/* rtl/palette_remap_image_scaler.sv */
`default_nettype none

// Nearest-neighbor image scaler with palette recolor. Items enter through a
// push/full queue port: palette writes, source pixel writes and emit requests;
// each emit returns the next output pixel in raster order on the empty/pop
// result queue. A front register and a two-entry command queue keep taking
// items while the back end executes them one at a time. A write is done at
// back-end dispatch; an emit steps through dispatch, source read, palette
// read and result write. The first pixel of each output row adds two 26-bit
// divisions in the shared serial divider (one quotient bit per cycle) and
// the row base multiply. Both stores are
// plain memories with no clearing pass, so no entry may be read before it has
// been written. SOURCE_DEPTH must be a power of two; source addresses wrap at
// it. Configuration writes are taken at any time (ready is always high) and
// belong between frames or while the block is idle.
module palette_remap_image_scaler #(
    parameter int SOURCE_DEPTH   = 65536,
    parameter int MAX_OUT_WIDTH  = 512,
    parameter int MAX_OUT_HEIGHT = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  prs_pkg::in_t                       item,
    input  logic                               pop,
    output logic                               empty,
    output prs_pkg::out_t                      result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [prs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [prs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    prs_pkg::cfg_t  cfg_reg;
    prs_pkg::in_t   front_cmd;
    prs_pkg::in_t   queue_cmd;
    prs_pkg::out_t  back_res;
    logic           front_push;
    logic           cmd_full;
    logic           cmd_empty;
    logic           cmd_pop;
    logic           res_full;
    logic           res_push;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.top_color         <= prs_pkg::RST_TOP_COLOR;
            cfg_reg.bottom_color      <= prs_pkg::RST_BOTTOM_COLOR;
            cfg_reg.top_range_base    <= prs_pkg::RST_TOP_BASE;
            cfg_reg.bottom_range_base <= prs_pkg::RST_BOTTOM_BASE;
            cfg_reg.source_width      <= prs_pkg::RST_SOURCE_WIDTH;
            cfg_reg.source_height     <= prs_pkg::RST_SOURCE_HEIGHT;
            cfg_reg.output_width      <= prs_pkg::RST_OUTPUT_WIDTH;
            cfg_reg.output_height     <= prs_pkg::RST_OUTPUT_HEIGHT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                prs_pkg::REG_TOP_COLOR:     cfg_reg.top_color         <= cfg_data[3:0];
                prs_pkg::REG_BOTTOM_COLOR:  cfg_reg.bottom_color      <= cfg_data[3:0];
                prs_pkg::REG_TOP_BASE:      cfg_reg.top_range_base    <= cfg_data[7:0];
                prs_pkg::REG_BOTTOM_BASE:   cfg_reg.bottom_range_base <= cfg_data[7:0];
                prs_pkg::REG_SOURCE_WIDTH:  cfg_reg.source_width      <= cfg_data[9:0];
                prs_pkg::REG_SOURCE_HEIGHT: cfg_reg.source_height     <= cfg_data[8:0];
                prs_pkg::REG_OUTPUT_WIDTH:  cfg_reg.output_width      <= cfg_data[9:0];
                prs_pkg::REG_OUTPUT_HEIGHT: cfg_reg.output_height     <= cfg_data[8:0];
                default:                    cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    prs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .cmd_push (front_push),
        .cmd_full (cmd_full),
        .cmd      (front_cmd)
    );

    prs_fifo #(
        .WIDTH ($bits(prs_pkg::in_t)),
        .DEPTH (2)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_push),
        .full  (cmd_full),
        .wdata (front_cmd),
        .pop   (cmd_pop),
        .empty (cmd_empty),
        .rdata (queue_cmd)
    );

    prs_back #(
        .SOURCE_DEPTH   (SOURCE_DEPTH),
        .MAX_OUT_WIDTH  (MAX_OUT_WIDTH),
        .MAX_OUT_HEIGHT (MAX_OUT_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cmd       (queue_cmd),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (back_res)
    );

    prs_fifo #(
        .WIDTH ($bits(prs_pkg::out_t)),
        .DEPTH (2)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .wdata (back_res),
        .pop   (pop),
        .empty (empty),
        .rdata (result)
    );

endmodule

`default_nettype wire

/* rtl/prs_checker.sv */
`default_nettype none

`include "palette_remap_image_scaler_defines.svh"

module prs_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          full,
    input logic          pop,
    input logic          empty,
    input prs_pkg::out_t result
);

    // A waiting result stays put until it is taken
    `PRS_ASSERT(a_result_hold, clk, rst_n, (!empty && !pop) |=> (!empty && $stable(result)), "result changed while waiting")

    // The last pixel of the frame closes a row too
    `PRS_ASSERT(a_frame_end_row_end, clk, rst_n, !empty |-> (!result.frame_end || result.row_end), "frame_end without row_end")

    // Reset leaves both queues open and empty
    `PRS_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |-> (empty && !full), "queues not idle in reset")

endmodule

bind palette_remap_image_scaler prs_checker u_prs_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .full   (full),
    .pop    (pop),
    .empty  (empty),
    .result (result)
);

`default_nettype wire
